/* rtl/sglc_pkg.sv */
package sglc_pkg;

  // Axis codes of a crossing.
  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // Width of the t value, unsigned Q1.16.
  localparam int T_BITS  = 17;
  localparam int T_SHIFT = 16;

endpackage

/* rtl/segment_grid_line_crossings_unit.sv */
// Channel   | Ports                              | Handshake
// ----------+------------------------------------+---------------------------
// input     | in_start_x/y, in_end_x/y           | start high, busy low
// result    | out_cross_x/y, out_fraction, ...   | out_valid strobe, no stall
//
// A segment keeps busy high while S_XAX and S_YAX scan its lines, each axis
// state ending on a closing step with no crossing (the y one may issue the empty
// result), so a new segment is taken only once the previous scan is done. Each
// crossing then passes an operand register, a multiply register, a divider
// pipeline of one quotient bit per stage (29 stages at the default widths) and
// the output register; results reach the ports one per cycle in order. The
// receiver cannot stall. Reset is synchronous and clears the sequencer and all valid bits.
module segment_grid_line_crossings_unit
  import sglc_pkg::*;
#(
  parameter int GRID_BITS = 5,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [GRID_BITS+FRAC_BITS-1:0] in_start_x,
  input  logic [GRID_BITS+FRAC_BITS-1:0] in_start_y,
  input  logic [GRID_BITS+FRAC_BITS-1:0] in_end_x,
  input  logic [GRID_BITS+FRAC_BITS-1:0] in_end_y,
  output logic                           out_valid,
  output logic [GRID_BITS+FRAC_BITS-1:0] out_cross_x,
  output logic [GRID_BITS+FRAC_BITS-1:0] out_cross_y,
  output logic [T_BITS-1:0]              out_fraction,
  output logic                           out_axis,
  output logic                           out_empty_res,
  output logic                           out_last
);

  localparam int CW    = GRID_BITS + FRAC_BITS;
  // Product num*|oe-os| plus os*d stays below 2^(2*CW+1).
  localparam int PW    = 2 * CW + 1;
  // t numerator num<<16; quotient up to 2^16.
  localparam int TNW   = CW + T_SHIFT;
  localparam int TQW   = T_SHIFT + 1;
  // Both dividers share one width so that they run in lock step.
  localparam int DQW   = (TNW > PW) ? TNW : PW;
  // Tag carries pos, axis, empty and last to the output.
  localparam int TAGW  = CW + 3;

  typedef enum logic [1:0] {S_IDLE, S_XAX, S_YAX} st_t;

  st_t                 st_r;
  logic [CW-1:0]       sx_r, sy_r, ex_r, ey_r;
  logic [GRID_BITS:0]  line_r;
  logic                any_r;

  // Axis operands for the current scan.
  logic [CW-1:0]       s_c, e_c, os_c, oe_c;
  logic                up_c;
  logic [GRID_BITS:0]  fe_c, first_c;
  logic                more_c;
  logic [CW-1:0]       pos_c, num_c, d_c;

  always_comb begin
    if (st_r == S_YAX) begin
      s_c = sy_r; e_c = ey_r; os_c = sx_r; oe_c = ex_r;
    end else begin
      s_c = sx_r; e_c = ex_r; os_c = sy_r; oe_c = ey_r;
    end
    up_c  = e_c > s_c;
    fe_c  = {1'b0, e_c[CW-1:FRAC_BITS]};
    more_c = up_c ? (line_r <= fe_c) : (line_r > fe_c);
    pos_c = {line_r[GRID_BITS-1:0], {FRAC_BITS{1'b0}}};
    num_c = up_c ? pos_c - s_c : s_c - pos_c;
    d_c   = up_c ? e_c - s_c : s_c - e_c;
  end

  // First line of the y scan, from the registered inputs.
  always_comb begin
    first_c = (ey_r > sy_r) ? {1'b0, sy_r[CW-1:FRAC_BITS]} + 1'b1
                            : {1'b0, sy_r[CW-1:FRAC_BITS]};
  end

  // Issue stage: one crossing per cycle into the operand stage while the axis scan has lines left.
  logic            iss_vld, iss_empty;
  logic            iss_last;
  logic            nxt_more_c;
  logic [GRID_BITS:0] nline_c;

  always_comb begin
    nline_c = up_c ? line_r + 1'b1 : line_r - 1'b1;
    // Whether the next cycle emits anything after this crossing.
    if (up_c) nxt_more_c = nline_c <= fe_c;
    else      nxt_more_c = nline_c > fe_c;
  end

  logic y_has_c;
  always_comb begin
    y_has_c = (ey_r > sy_r) ? (first_c <= {1'b0, ey_r[CW-1:FRAC_BITS]})
                            : (first_c > {1'b0, ey_r[CW-1:FRAC_BITS]});
    iss_vld   = (st_r != S_IDLE) && more_c;
    iss_empty = (st_r == S_YAX) && !more_c && !any_r;
    iss_last  = (st_r == S_YAX) ? !nxt_more_c : (!nxt_more_c && !y_has_c);
  end

  // Sequencer over the lines of both axes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      any_r <= 1'b0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (start) begin
            st_r  <= S_XAX;
            any_r <= 1'b0;
          end
        end
        S_XAX: begin
          if (more_c) begin
            any_r <= 1'b1;
          end else begin
            st_r <= S_YAX;
          end
        end
        S_YAX: begin
          if (more_c) begin
            any_r <= 1'b1;
          end else begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
    if (st_r == S_IDLE && start) begin
      sx_r   <= in_start_x;
      sy_r   <= in_start_y;
      ex_r   <= in_end_x;
      ey_r   <= in_end_y;
      line_r <= (in_end_x > in_start_x) ? {1'b0, in_start_x[CW-1:FRAC_BITS]} + 1'b1
                                        : {1'b0, in_start_x[CW-1:FRAC_BITS]};
    end else if (st_r == S_XAX && !more_c) begin
      line_r <= first_c;
    end else if (more_c) begin
      line_r <= nline_c;
    end
  end

  assign busy = (st_r != S_IDLE);

  // Operand stage: the scan operands of the issued crossing, with |oe-os| and its sign.
  logic            a_vld_r;
  logic [CW-1:0]   a_num_r, a_d_r, a_os_r, a_dif_r, a_pos_r;
  logic            a_neg_r, a_axis_r, a_empty_r, a_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= iss_vld || iss_empty;
    end
    a_num_r   <= num_c;
    a_d_r     <= iss_empty ? CW'(1) : d_c;
    a_os_r    <= os_c;
    a_neg_r   <= oe_c < os_c;
    a_dif_r   <= (oe_c >= os_c) ? oe_c - os_c : os_c - oe_c;
    a_pos_r   <= pos_c;
    a_axis_r  <= (st_r == S_YAX) ? AXIS_Y : AXIS_X;
    a_empty_r <= iss_empty;
    a_last_r  <= iss_empty || iss_last;
  end

  // Multiply stage: os*d + num*(oe-os), kept as magnitude since result >= 0.
  logic            m_vld_r;
  logic [PW-1:0]   m_prod_r;
  logic [CW-1:0]   m_num_r, m_d_r, m_pos_r;
  logic            m_axis_r, m_empty_r, m_last_r;
  logic [2*CW-1:0] osd_c, nmd_c;

  always_comb begin
    osd_c = a_os_r * a_d_r;
    nmd_c = a_num_r * a_dif_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else begin
      m_vld_r <= a_vld_r;
    end
    m_prod_r  <= a_neg_r ? {1'b0, osd_c} - {1'b0, nmd_c}
                         : {1'b0, osd_c} + {1'b0, nmd_c};
    m_num_r   <= a_num_r;
    m_d_r     <= a_d_r;
    m_pos_r   <= a_pos_r;
    m_axis_r  <= a_axis_r;
    m_empty_r <= a_empty_r;
    m_last_r  <= a_last_r;
  end

  // Both divisions run in lock step pipelines of equal depth.
  logic            dt_vld, do_vld;
  logic [DQW-1:0]  dt_quo_full, do_quo;
  logic [TQW-1:0]  dt_quo;
  logic [TAGW-1:0] dt_tag, do_tag;

  sglc_div #(.NUM_W(DQW), .DEN_W(CW), .Q_W(DQW), .TAG_W(TAGW)) u_tdiv (
    .clk, .rst_n,
    .in_vld (m_vld_r),
    .in_num (DQW'({m_num_r, {T_SHIFT{1'b0}}})),
    .in_den (m_d_r),
    .in_tag ({m_pos_r, m_axis_r, m_empty_r, m_last_r}),
    .out_vld(dt_vld),
    .out_quo(dt_quo_full),
    .out_tag(dt_tag)
  );
  assign dt_quo = dt_quo_full[TQW-1:0];

  sglc_div #(.NUM_W(DQW), .DEN_W(CW), .Q_W(DQW), .TAG_W(TAGW)) u_odiv (
    .clk, .rst_n,
    .in_vld (m_vld_r),
    .in_num (DQW'(m_prod_r)),
    .in_den (m_d_r),
    .in_tag ({m_pos_r, m_axis_r, m_empty_r, m_last_r}),
    .out_vld(do_vld),
    .out_quo(do_quo),
    .out_tag(do_tag)
  );

  // Output register.
  logic [CW-1:0] o_pos;
  logic          o_axis, o_empty, o_last;
  assign {o_pos, o_axis, o_empty, o_last} = do_tag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= do_vld;
    end
    out_empty_res <= o_empty;
    out_last      <= o_last;
    out_axis      <= o_empty ? 1'b0 : o_axis;
    out_fraction  <= o_empty ? '0 : dt_quo;
    if (o_empty) begin
      out_cross_x <= '0;
      out_cross_y <= '0;
    end else if (o_axis == AXIS_X) begin
      out_cross_x <= o_pos;
      out_cross_y <= do_quo[CW-1:0];
    end else begin
      out_cross_x <= do_quo[CW-1:0];
      out_cross_y <= o_pos;
    end
  end

  // The t divider's valid and tag duplicate the other one's; upper quotient bits of both are unused.
  logic unused_c;
  assign unused_c = ^{dt_vld, dt_tag, dt_quo_full[DQW-1:TQW], do_quo[DQW-1:CW]};

endmodule

/* rtl/sglc_div.sv */
// Pipelined restoring divider: one quotient bit per stage.
// Divides the low Q_W bits of num by den, giving an integer quotient.
module sglc_div #(
  parameter int NUM_W = 34,
  parameter int DEN_W = 13,
  parameter int Q_W   = 21,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_vld,
  output logic [Q_W-1:0]   out_quo,
  output logic [TAG_W-1:0] out_tag
);

  // Remainder is wide enough that a shifted copy never overflows.
  localparam int REM_W = DEN_W + 1;

  logic [Q_W:0]                vld_r;
  logic [NUM_W-1:0]            num_r [Q_W+1];
  logic [DEN_W-1:0]            den_r [Q_W+1];
  logic [REM_W-1:0]            rem_r [Q_W+1];
  logic [Q_W-1:0]              quo_r [Q_W+1];
  logic [TAG_W-1:0]            tag_r [Q_W+1];

  // Stage zero loads the operands.
  always_comb begin
    vld_r[0] = in_vld;
    num_r[0] = in_num;
    den_r[0] = in_den;
    rem_r[0] = '0;
    quo_r[0] = '0;
    tag_r[0] = in_tag;
  end

  // Each stage brings in one numerator bit, from the top quotient bit down.
  for (genvar g = 0; g < Q_W; g++) begin : g_stage
    logic [REM_W:0] sh;
    logic [REM_W:0] diff;
    always_comb begin
      sh   = {rem_r[g], num_r[g][Q_W-1-g]};
      diff = sh - {2'b00, den_r[g]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
      num_r[g+1] <= num_r[g];
      den_r[g+1] <= den_r[g];
      tag_r[g+1] <= tag_r[g];
      if (!diff[REM_W]) begin
        rem_r[g+1] <= diff[REM_W-1:0];
        quo_r[g+1] <= quo_r[g] | (Q_W'(1) << (Q_W-1-g));
      end else begin
        rem_r[g+1] <= sh[REM_W-1:0];
        quo_r[g+1] <= quo_r[g];
      end
    end
  end

  assign out_vld = vld_r[Q_W];
  assign out_quo = quo_r[Q_W];
  assign out_tag = tag_r[Q_W];

endmodule

/* rtl/sglc_check.sv */
// Port-level checks on the crossing unit.
module sglc_check
  import sglc_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid,
  input logic out_empty_res,
  input logic out_last,
  input logic out_axis,
  input logic [T_BITS-1:0] out_fraction
);

  // An accepted segment makes the unit busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("not busy after transfer");

  // An empty result is always the last one.
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_last) else $error("empty not last");

  // t never exceeds one.
  a_frac: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fraction <= 17'h10000) else $error("t above one");

  // Y crossings never precede x crossings of the same segment.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last && out_axis |=> !(out_valid && !out_axis))
    else $error("axis order");

endmodule

bind segment_grid_line_crossings_unit sglc_check u_sglc_check (
  .clk, .rst_n, .start, .busy, .out_valid, .out_empty_res, .out_last,
  .out_axis, .out_fraction
);
